// ===== hw/rtl/sqlts_pkg.sv =====
// sqlts_pkg: shared types, token codes, scanner modes and keyword table
// used by the sql token scanner and its keyword matcher; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package sqlts_pkg;

    localparam int KW_MAX_CHARS_DEF = 8;
    localparam int CNT_BITS_DEF     = 16;
    localparam int KW_COUNT         = 52;
    localparam int KW_TEXT_BITS     = 64;
    localparam int FIFO_DEPTH       = 4;

    localparam logic [6:0] K_END    = 7'd0;
    localparam logic [6:0] K_IDENT  = 7'd1;
    localparam logic [6:0] K_NUMBER = 7'd2;
    localparam logic [6:0] K_STRING = 7'd3;
    localparam logic [6:0] K_ERROR  = 7'd4;
    localparam logic [6:0] K_LPAREN = 7'd5;
    localparam logic [6:0] K_RPAREN = 7'd6;
    localparam logic [6:0] K_COMMA  = 7'd7;
    localparam logic [6:0] K_DOT    = 7'd8;
    localparam logic [6:0] K_SEMI   = 7'd9;
    localparam logic [6:0] K_STAR   = 7'd10;
    localparam logic [6:0] K_PLUS   = 7'd11;
    localparam logic [6:0] K_MINUS  = 7'd12;
    localparam logic [6:0] K_SLASH  = 7'd13;
    localparam logic [6:0] K_EQ     = 7'd14;
    localparam logic [6:0] K_NE     = 7'd15;
    localparam logic [6:0] K_LT     = 7'd16;
    localparam logic [6:0] K_LE     = 7'd17;
    localparam logic [6:0] K_GT     = 7'd18;
    localparam logic [6:0] K_GE     = 7'd19;

    localparam logic [3:0] M_IDLE    = 4'd0;
    localparam logic [3:0] M_MINUS   = 4'd1;
    localparam logic [3:0] M_COMMENT = 4'd2;
    localparam logic [3:0] M_IDENT   = 4'd3;
    localparam logic [3:0] M_INT     = 4'd4;
    localparam logic [3:0] M_FRAC    = 4'd5;
    localparam logic [3:0] M_STRING  = 4'd6;
    localparam logic [3:0] M_LT      = 4'd7;
    localparam logic [3:0] M_GT      = 4'd8;
    localparam logic [3:0] M_BANG    = 4'd9;

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_QUOTE = 8'h27;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_BANG  = 8'h21;

    typedef struct packed {
        logic [6:0]  kind;
        logic [15:0] line;
        logic [15:0] column;
        logic [15:0] length;
        logic [62:0] ival;
        logic        frac_flag;
        logic        last;
    } token_t;

    typedef struct packed {
        logic [KW_TEXT_BITS-1:0] text;
        logic [3:0]              len;
        logic [6:0]              code;
    } kw_entry_t;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
    endfunction

    // spelling right-aligned, last character in the lowest byte
    function automatic kw_entry_t kw_entry(input int idx);
        kw_entry_t e;
        e = '0;
        unique case (idx)
            0:  e = '{64'("SELECT"),   4'd6, 7'd20};
            1:  e = '{64'("FROM"),     4'd4, 7'd21};
            2:  e = '{64'("WHERE"),    4'd5, 7'd22};
            3:  e = '{64'("INSERT"),   4'd6, 7'd23};
            4:  e = '{64'("INTO"),     4'd4, 7'd24};
            5:  e = '{64'("VALUES"),   4'd6, 7'd25};
            6:  e = '{64'("DELETE"),   4'd6, 7'd26};
            7:  e = '{64'("UPDATE"),   4'd6, 7'd27};
            8:  e = '{64'("SET"),      4'd3, 7'd28};
            9:  e = '{64'("CREATE"),   4'd6, 7'd29};
            10: e = '{64'("TABLE"),    4'd5, 7'd30};
            11: e = '{64'("INDEX"),    4'd5, 7'd31};
            12: e = '{64'("DROP"),     4'd4, 7'd32};
            13: e = '{64'("AND"),      4'd3, 7'd33};
            14: e = '{64'("OR"),       4'd2, 7'd34};
            15: e = '{64'("NOT"),      4'd3, 7'd35};
            16: e = '{64'("IN"),       4'd2, 7'd36};
            17: e = '{64'("LIKE"),     4'd4, 7'd37};
            18: e = '{64'("IS"),       4'd2, 7'd38};
            19: e = '{64'("NULL"),     4'd4, 7'd39};
            20: e = '{64'("TRUE"),     4'd4, 7'd40};
            21: e = '{64'("FALSE"),    4'd5, 7'd41};
            22: e = '{64'("JOIN"),     4'd4, 7'd42};
            23: e = '{64'("ON"),       4'd2, 7'd43};
            24: e = '{64'("LEFT"),     4'd4, 7'd44};
            25: e = '{64'("RIGHT"),    4'd5, 7'd45};
            26: e = '{64'("INNER"),    4'd5, 7'd46};
            27: e = '{64'("OUTER"),    4'd5, 7'd47};
            28: e = '{64'("GROUP"),    4'd5, 7'd48};
            29: e = '{64'("BY"),       4'd2, 7'd49};
            30: e = '{64'("ORDER"),    4'd5, 7'd50};
            31: e = '{64'("ASC"),      4'd3, 7'd51};
            32: e = '{64'("DESC"),     4'd4, 7'd52};
            33: e = '{64'("LIMIT"),    4'd5, 7'd53};
            34: e = '{64'("OFFSET"),   4'd6, 7'd54};
            35: e = '{64'("BEGIN"),    4'd5, 7'd55};
            36: e = '{64'("COMMIT"),   4'd6, 7'd56};
            37: e = '{64'("ROLLBACK"), 4'd8, 7'd57};
            38: e = '{64'("IF"),       4'd2, 7'd58};
            39: e = '{64'("EXISTS"),   4'd6, 7'd59};
            40: e = '{64'("UNIQUE"),   4'd6, 7'd60};
            41: e = '{64'("INT"),      4'd3, 7'd61};
            42: e = '{64'("INTEGER"),  4'd7, 7'd61};
            43: e = '{64'("BIGINT"),   4'd6, 7'd62};
            44: e = '{64'("FLOAT"),    4'd5, 7'd63};
            45: e = '{64'("DOUBLE"),   4'd6, 7'd64};
            46: e = '{64'("TEXT"),     4'd4, 7'd65};
            47: e = '{64'("VARCHAR"),  4'd7, 7'd66};
            48: e = '{64'("CHAR"),     4'd4, 7'd67};
            49: e = '{64'("BOOL"),     4'd4, 7'd68};
            50: e = '{64'("BOOLEAN"),  4'd7, 7'd68};
            51: e = '{64'("DISTINCT"), 4'd8, 7'd69};
            default: e = '0;
        endcase
        return e;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/sql_token_scanner.sv =====
// sql_token_scanner: streaming sql lexer, one text byte per item in,
// one token per item out; depends on sqlts_pkg and sqlts_kw_match
//
// input channel s_*: s_tdata carries one text byte, s_tuser set means end
// of input (flush any pending token, emit an end token, return to reset
// state). output channel m_*: one token per item, tlast on the final token
// caused by one input item.
// each input item is scanned in the cycle it is accepted; its zero, one or
// two tokens are written into a four-entry result queue and the first one
// is visible on m_* the next cycle when the queue was empty.
// throughput is one input item per cycle while each item gives at most one
// token and the receiver does not stall; items giving two tokens fill the
// queue faster than its single read port drains it, until s_tready drops.
// s_tready is high while the queue has room for two tokens; when the
// receiver stalls the queue fills and s_tready drops once three or four
// tokens are queued. tokens wait in the queue unchanged until taken.
// reset (rst_n low, asynchronous) empties the queue, sets the line
// counter to 1, the column counter to 0 and the scanner to idle.
`timescale 1ns / 1ps
`default_nettype none
module sql_token_scanner #(
    parameter int KEYWORD_MAX_CHARS = sqlts_pkg::KW_MAX_CHARS_DEF,
    parameter int COUNTER_BITS      = sqlts_pkg::CNT_BITS_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,  // char_in
    input  wire logic         s_tuser,  // command
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [111:0]      m_tdata,  // start_line, start_column, token_length, int_value, 0
    output logic [7:0]        m_tuser,  // token_kind, number_is_float
    output logic              m_tlast   // last_of_run
);
    import sqlts_pkg::*;

    localparam int CB = COUNTER_BITS;
    localparam int WB = KEYWORD_MAX_CHARS * 8;
    localparam logic [CB-1:0] CNT_MAX = {CB{1'b1}};
    localparam int PB = $clog2(FIFO_DEPTH);

    logic [3:0]    mode_reg, mode_next;
    logic [WB-1:0] word_reg, word_next;
    logic          tl_reg, tl_next;
    logic [CB-1:0] cnt_reg, cnt_next;
    logic [62:0]   acc_reg, acc_next;
    logic          sdo_reg, sdo_next;
    logic [CB-1:0] line_reg, line_next;
    logic [CB-1:0] col_reg, col_next;

    token_t        fifo_reg [FIFO_DEPTH];
    logic [PB-1:0] wp_reg, rp_reg;
    logic [PB:0]   count_reg;

    logic [6:0]    kw_kind;
    logic          a_v, b_v, go;
    token_t        a_t, b_t;
    logic [7:0]    c;
    logic          s_fire, m_fire;
    logic [66:0]   dsum;

    sqlts_kw_match #(
        .KEYWORD_MAX_CHARS(KEYWORD_MAX_CHARS),
        .COUNTER_BITS(COUNTER_BITS)
    ) u_kw (
        .word(word_reg),
        .word_len(cnt_reg),
        .too_long(tl_reg),
        .kind(kw_kind)
    );

    function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] v);
        return (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
    endfunction

    function automatic logic [15:0] clamp16(input logic [CB-1:0] v);
        logic [CB+15:0] w;
        w = (CB+16)'(v);
        return (w > (CB+16)'(16'hFFFF)) ? 16'hFFFF : w[15:0];
    endfunction

    function automatic token_t tok(input logic [6:0] kind, input logic [CB-1:0] len,
                                   input logic [62:0] ival, input logic isf,
                                   input logic [CB-1:0] line, input logic [CB-1:0] col);
        token_t t;
        t.kind      = kind;
        t.line      = clamp16(line);
        t.column    = clamp16((col >= len) ? col - len : '0);
        t.length    = clamp16(len);
        t.ival      = ival;
        t.frac_flag = isf;
        t.last      = 1'b0;
        return t;
    endfunction

    assign s_fire   = s_tvalid && s_tready;
    assign m_fire   = m_tvalid && m_tready;
    assign s_tready = count_reg <= (PB+1)'(FIFO_DEPTH - 2);
    assign c        = s_tdata;

    always_comb
    begin
        logic [66:0] ext;
        ext  = {4'b0, acc_reg};
        dsum = (ext << 3) + (ext << 1) + 67'(c - 8'h30);
    end

    always_comb
    begin
        mode_next = mode_reg;
        word_next = word_reg;
        tl_next   = tl_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        sdo_next  = sdo_reg;
        line_next = line_reg;
        col_next  = col_reg;
        a_v = 1'b0;
        b_v = 1'b0;
        a_t = '0;
        b_t = '0;
        go  = 1'b0;
        if (s_tuser)
        begin
            a_v = 1'b1;
            unique case (mode_reg)
                M_MINUS:  a_t = tok(K_MINUS, CB'(1), '0, 1'b0, line_reg, col_reg);
                M_IDENT:  a_t = tok(kw_kind, cnt_reg, '0, 1'b0, line_reg, col_reg);
                M_INT, M_FRAC:
                    a_t = tok(K_NUMBER, cnt_reg,
                              ((mode_reg == M_FRAC) || sdo_reg) ? '0 : acc_reg,
                              (mode_reg == M_FRAC) || sdo_reg, line_reg, col_reg);
                M_STRING: a_t = tok(K_ERROR, cnt_reg, '0, 1'b0, line_reg, col_reg);
                M_LT:     a_t = tok(K_LT, CB'(1), '0, 1'b0, line_reg, col_reg);
                M_GT:     a_t = tok(K_GT, CB'(1), '0, 1'b0, line_reg, col_reg);
                M_BANG:   a_t = tok(K_ERROR, CB'(1), '0, 1'b0, line_reg, col_reg);
                default:  a_v = 1'b0;
            endcase
            b_v = 1'b1;
            b_t = tok(K_END, '0, '0, 1'b0, line_reg, col_reg);
            mode_next = M_IDLE;
            word_next = '0;
            tl_next   = 1'b0;
            cnt_next  = '0;
            acc_next  = '0;
            sdo_next  = 1'b0;
            line_next = CB'(1);
            col_next  = '0;
        end
        else
        begin
            unique case (mode_reg)
                M_MINUS:
                begin
                    if (c == CH_MINUS)
                    begin
                        mode_next = M_COMMENT;
                        col_next  = sat_inc(col_reg);
                    end
                    else
                    begin
                        a_v = 1'b1;
                        a_t = tok(K_MINUS, CB'(1), '0, 1'b0, line_reg, col_reg);
                        go  = 1'b1;
                    end
                end
                M_COMMENT:
                begin
                    if (c != CH_NL)
                    begin
                        col_next = sat_inc(col_reg);
                    end
                    else
                    begin
                        go = 1'b1;
                    end
                end
                M_IDENT:
                begin
                    if (is_alpha(c) || is_digit(c) || c == CH_UNDER)
                    begin
                        if (cnt_reg < CB'(KEYWORD_MAX_CHARS))
                        begin
                            word_next = {word_reg[WB-9:0], to_upper(c)};
                        end
                        else
                        begin
                            tl_next = 1'b1;
                        end
                        cnt_next = sat_inc(cnt_reg);
                        col_next = sat_inc(col_reg);
                    end
                    else
                    begin
                        a_v = 1'b1;
                        a_t = tok(kw_kind, cnt_reg, '0, 1'b0, line_reg, col_reg);
                        go  = 1'b1;
                    end
                end
                M_INT, M_FRAC:
                begin
                    if (is_digit(c) || (c == CH_DOT && mode_reg == M_INT))
                    begin
                        if (c == CH_DOT)
                        begin
                            mode_next = M_FRAC;
                        end
                        else if (mode_reg == M_INT && !sdo_reg)
                        begin
                            if (dsum[66:63] != 4'b0)
                            begin
                                sdo_next = 1'b1;
                                acc_next = '0;
                            end
                            else
                            begin
                                acc_next = dsum[62:0];
                            end
                        end
                        cnt_next = sat_inc(cnt_reg);
                        col_next = sat_inc(col_reg);
                    end
                    else
                    begin
                        a_v = 1'b1;
                        a_t = tok(K_NUMBER, cnt_reg,
                                  ((mode_reg == M_FRAC) || sdo_reg) ? '0 : acc_reg,
                                  (mode_reg == M_FRAC) || sdo_reg, line_reg, col_reg);
                        go  = 1'b1;
                    end
                end
                M_STRING:
                begin
                    col_next = sat_inc(col_reg);
                    if (c == CH_QUOTE)
                    begin
                        a_v = 1'b1;
                        a_t = tok(K_STRING, cnt_reg, '0, 1'b0, line_reg, col_next);
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        cnt_next = sat_inc(cnt_reg);
                    end
                end
                M_LT:
                begin
                    if (c == CH_GT || c == CH_EQ)
                    begin
                        col_next  = sat_inc(col_reg);
                        a_v = 1'b1;
                        a_t = tok((c == CH_GT) ? K_NE : K_LE, CB'(2), '0, 1'b0,
                                  line_reg, col_next);
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        a_v = 1'b1;
                        a_t = tok(K_LT, CB'(1), '0, 1'b0, line_reg, col_reg);
                        go  = 1'b1;
                    end
                end
                M_GT, M_BANG:
                begin
                    if (c == CH_EQ)
                    begin
                        col_next  = sat_inc(col_reg);
                        a_v = 1'b1;
                        a_t = tok((mode_reg == M_GT) ? K_GE : K_NE, CB'(2), '0, 1'b0,
                                  line_reg, col_next);
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        a_v = 1'b1;
                        a_t = tok((mode_reg == M_GT) ? K_GT : K_ERROR, CB'(1), '0, 1'b0,
                                  line_reg, col_reg);
                        go  = 1'b1;
                    end
                end
                default: go = 1'b1;
            endcase

            if (go)
            begin
                mode_next = M_IDLE;
                if (is_space(c))
                begin
                    if (c == CH_NL)
                    begin
                        line_next = sat_inc(line_reg);
                        col_next  = CB'(1);
                    end
                    else
                    begin
                        col_next = sat_inc(col_reg);
                    end
                end
                else
                begin
                    col_next = sat_inc(col_reg);
                    if (is_alpha(c) || c == CH_UNDER)
                    begin
                        mode_next = M_IDENT;
                        word_next = WB'(to_upper(c));
                        tl_next   = 1'b0;
                        cnt_next  = CB'(1);
                    end
                    else if (is_digit(c))
                    begin
                        mode_next = M_INT;
                        acc_next  = 63'(c - 8'h30);
                        sdo_next  = 1'b0;
                        cnt_next  = CB'(1);
                    end
                    else
                    begin
                        priority case (c)
                            CH_MINUS: mode_next = M_MINUS;
                            CH_QUOTE:
                            begin
                                mode_next = M_STRING;
                                cnt_next  = '0;
                            end
                            CH_LT:   mode_next = M_LT;
                            CH_GT:   mode_next = M_GT;
                            CH_BANG: mode_next = M_BANG;
                            default:
                            begin
                                b_v = 1'b1;
                                priority case (c)
                                    8'h28:   b_t.kind = K_LPAREN;
                                    8'h29:   b_t.kind = K_RPAREN;
                                    8'h2C:   b_t.kind = K_COMMA;
                                    CH_DOT:  b_t.kind = K_DOT;
                                    8'h3B:   b_t.kind = K_SEMI;
                                    8'h2A:   b_t.kind = K_STAR;
                                    8'h2B:   b_t.kind = K_PLUS;
                                    8'h2F:   b_t.kind = K_SLASH;
                                    CH_EQ:   b_t.kind = K_EQ;
                                    default: b_t.kind = K_ERROR;
                                endcase
                                b_t = tok(b_t.kind, CB'(1), '0, 1'b0, line_reg, col_next);
                            end
                        endcase
                    end
                end
            end
        end
        if (b_v)
        begin
            b_t.last = 1'b1;
        end
        else
        begin
            a_t.last = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            word_reg <= '0;
            tl_reg   <= 1'b0;
            cnt_reg  <= '0;
            acc_reg  <= '0;
            sdo_reg  <= 1'b0;
            line_reg <= CB'(1);
            col_reg  <= '0;
        end
        else if (s_fire)
        begin
            mode_reg <= mode_next;
            word_reg <= word_next;
            tl_reg   <= tl_next;
            cnt_reg  <= cnt_next;
            acc_reg  <= acc_next;
            sdo_reg  <= sdo_next;
            line_reg <= line_next;
            col_reg  <= col_next;
        end
    end

    // result queue
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            if (a_v)
            begin
                fifo_reg[wp_reg] <= a_t;
                if (b_v)
                begin
                    fifo_reg[wp_reg + 1'b1] <= b_t;
                end
            end
            else if (b_v)
            begin
                fifo_reg[wp_reg] <= b_t;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        logic [PB:0] nwr;
        if (!rst_n)
        begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            nwr = s_fire ? (PB+1)'(a_v) + (PB+1)'(b_v) : '0;
            wp_reg    <= wp_reg + nwr[PB-1:0];
            rp_reg    <= rp_reg + PB'(m_fire);
            count_reg <= count_reg + nwr - (PB+1)'(m_fire);
        end
    end

    assign m_tvalid = count_reg != '0;
    assign m_tdata  = {1'b0, fifo_reg[rp_reg].ival, fifo_reg[rp_reg].length,
                       fifo_reg[rp_reg].column, fifo_reg[rp_reg].line};
    assign m_tuser  = {fifo_reg[rp_reg].frac_flag, fifo_reg[rp_reg].kind};
    assign m_tlast  = fifo_reg[rp_reg].last;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (PB+1)'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_flush_state: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && s_tuser) |=> (mode_reg == M_IDLE && line_reg == CB'(1)
                                 && col_reg == '0))
        else $error("flush did not restore reset state");

    a_flush_token: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && s_tuser) |=> m_tvalid)
        else $error("flush produced no token");

    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == M_INT) |-> !(sdo_reg && acc_reg != '0))
        else $error("overflowed number kept a value");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/sqlts_kw_match.sv =====
// sqlts_kw_match: parallel compare of a buffered identifier against the
// keyword table; depends on sqlts_pkg
`timescale 1ns / 1ps
`default_nettype none
module sqlts_kw_match #(
    parameter int KEYWORD_MAX_CHARS = sqlts_pkg::KW_MAX_CHARS_DEF,
    parameter int COUNTER_BITS      = sqlts_pkg::CNT_BITS_DEF
) (
    input  wire logic [KEYWORD_MAX_CHARS*8-1:0] word,
    input  wire logic [COUNTER_BITS-1:0]        word_len,
    input  wire logic                           too_long,
    output logic [6:0]                          kind
);
    import sqlts_pkg::*;

    localparam int WB = KEYWORD_MAX_CHARS * 8;

    logic [KW_COUNT-1:0] hit;

    always_comb
    begin
        kw_entry_t e;
        for (int i = 0; i < KW_COUNT; i++)
        begin
            e = kw_entry(i);
            hit[i] = !too_long && (word_len == COUNTER_BITS'(e.len))
                && (word == WB'(e.text));
        end
    end

    always_comb
    begin
        kw_entry_t k;
        kind = K_IDENT;
        for (int i = KW_COUNT - 1; i >= 0; i--)
        begin
            k = kw_entry(i);
            if (hit[i])
            begin
                kind = k.code;
            end
        end
    end

endmodule
`default_nettype wire

// ===== tb/sql_token_scanner_test.sv =====
// sql_token_scanner_test: self-checking bench for the streaming sql lexer;
// text bytes go in, predicted tokens are compared field by field with m_*
// depends on sqlts_pkg and the sql_token_scanner rtl
`timescale 1ns / 1ps
module sql_token_scanner_test;
    import sqlts_pkg::*;

    localparam longint unsigned INT63_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam int CNT_MAX = 65535;
    localparam int STALL_LIMIT = 3000;
    localparam int NO_CHECK = -1;

    typedef struct {
        bit  flush;
        byte ch;
        int  first_kind;
    } text_item_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [111:0] m_tdata;
    logic [7:0]   m_tuser;
    logic         m_tlast;

    sql_token_scanner i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // keyword spellings, right-aligned and zero padded
    logic [63:0] kw_text [52] = '{
        "SELECT", "FROM", "WHERE", "INSERT", "INTO", "VALUES", "DELETE", "UPDATE", "SET",
        "CREATE", "TABLE", "INDEX", "DROP", "AND", "OR", "NOT", "IN", "LIKE", "IS", "NULL",
        "TRUE", "FALSE", "JOIN", "ON", "LEFT", "RIGHT", "INNER", "OUTER", "GROUP", "BY",
        "ORDER", "ASC", "DESC", "LIMIT", "OFFSET", "BEGIN", "COMMIT", "ROLLBACK", "IF",
        "EXISTS", "UNIQUE", "INT", "INTEGER", "BIGINT", "FLOAT", "DOUBLE", "TEXT",
        "VARCHAR", "CHAR", "BOOL", "BOOLEAN", "DISTINCT"};
    int kw_code [52] = '{
        20, 21, 22, 23, 24, 25, 26, 27, 28, 29, 30, 31, 32, 33, 34, 35, 36, 37, 38, 39,
        40, 41, 42, 43, 44, 45, 46, 47, 48, 49, 50, 51, 52, 53, 54, 55, 56, 57, 58, 59,
        60, 61, 61, 62, 63, 64, 65, 66, 67, 68, 68, 69};

    // lexer state mirror
    logic [3:0]      lex_mode;
    logic [63:0]     word_text;
    bit              word_too_long;
    int              lexeme_len;
    longint unsigned num_acc;
    bit              num_float;
    int              line_cnt;
    int              col_cnt;

    token_t     run_tokens[$];
    token_t     token_q[$];
    text_item_t text_q[$];
    int         errors = 0;
    int         tokens_seen = 0;
    int         items_sent = 0;
    int         idle_cycles = 0;

    function automatic int sat_inc(int v);
        return (v >= CNT_MAX) ? CNT_MAX : v + 1;
    endfunction

    function automatic bit is_letter(byte unsigned c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic bit is_num(byte unsigned c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic byte unsigned upper(byte unsigned c);
        return (c >= "a" && c <= "z") ? c - 8'd32 : c;
    endfunction

    function automatic void lexer_clear();
        lex_mode = M_IDLE;
        word_text = '0;
        word_too_long = 0;
        lexeme_len = 0;
        num_acc = 0;
        num_float = 0;
        line_cnt = 1;
        col_cnt = 0;
    endfunction

    function automatic void emit_token(logic [6:0] kind, int len, longint unsigned val,
                                       bit flt);
        token_t t;
        if (run_tokens.size() >= 3)
            return;
        t.kind = kind;
        t.line = 16'(line_cnt);
        t.column = 16'((col_cnt >= len) ? col_cnt - len : 0);
        t.length = 16'(len);
        t.ival = val[62:0];
        t.frac_flag = flt;
        t.last = 1'b0;
        run_tokens.push_back(t);
    endfunction

    function automatic void finish_word();
        logic [6:0] kind;
        kind = K_IDENT;
        if (!word_too_long && lexeme_len <= KW_MAX_CHARS_DEF)
            for (int i = 0; i < 52; i++)
                if (kw_text[i] == word_text)
                    kind = 7'(kw_code[i]);
        emit_token(kind, lexeme_len, 0, 0);
    endfunction

    function automatic void finish_num();
        bit flt;
        flt = (lex_mode == M_FRAC) || num_float;
        emit_token(K_NUMBER, lexeme_len, flt ? 0 : num_acc, flt);
    endfunction

    function automatic void take_digit(byte unsigned c);
        longint unsigned d;
        d = c - "0";
        if (num_float)
            return;
        if (num_acc > (INT63_MAX - d) / 10)
        begin
            num_float = 1;
            num_acc = 0;
        end
        else
            num_acc = num_acc * 10 + d;
    endfunction

    function automatic void scan_fresh(byte unsigned c);
        logic [6:0] kind;
        if (c == " " || (c >= 9 && c <= 13))
        begin
            if (c == 8'h0A)
            begin
                line_cnt = sat_inc(line_cnt);
                col_cnt = 0;
            end
            col_cnt = sat_inc(col_cnt);
            return;
        end
        col_cnt = sat_inc(col_cnt);
        if (is_letter(c) || c == "_")
        begin
            lex_mode = M_IDENT;
            word_text = 64'(upper(c));
            word_too_long = 0;
            lexeme_len = 1;
            return;
        end
        if (is_num(c))
        begin
            lex_mode = M_INT;
            num_acc = 0;
            num_float = 0;
            lexeme_len = 1;
            take_digit(c);
            return;
        end
        case (c)
            "-":
            begin
                lex_mode = M_MINUS;
                return;
            end
            "'":
            begin
                lex_mode = M_STRING;
                lexeme_len = 0;
                return;
            end
            "<":
            begin
                lex_mode = M_LT;
                return;
            end
            ">":
            begin
                lex_mode = M_GT;
                return;
            end
            "!":
            begin
                lex_mode = M_BANG;
                return;
            end
            "(": kind = K_LPAREN;
            ")": kind = K_RPAREN;
            ",": kind = K_COMMA;
            ".": kind = K_DOT;
            ";": kind = K_SEMI;
            "*": kind = K_STAR;
            "+": kind = K_PLUS;
            "/": kind = K_SLASH;
            "=": kind = K_EQ;
            default: kind = K_ERROR;
        endcase
        emit_token(kind, 1, 0, 0);
    endfunction

    function automatic void scan_char(byte unsigned c);
        case (lex_mode)
            M_MINUS:
            begin
                if (c == "-")
                begin
                    lex_mode = M_COMMENT;
                    col_cnt = sat_inc(col_cnt);
                    return;
                end
                emit_token(K_MINUS, 1, 0, 0);
            end
            M_COMMENT:
            begin
                if (c != 8'h0A)
                begin
                    col_cnt = sat_inc(col_cnt);
                    return;
                end
            end
            M_IDENT:
            begin
                if (is_letter(c) || is_num(c) || c == "_")
                begin
                    if (lexeme_len < KW_MAX_CHARS_DEF)
                        word_text = {word_text[55:0], upper(c)};
                    else
                        word_too_long = 1;
                    lexeme_len = sat_inc(lexeme_len);
                    col_cnt = sat_inc(col_cnt);
                    return;
                end
                finish_word();
            end
            M_INT, M_FRAC:
            begin
                if (is_num(c) || (c == "." && lex_mode == M_INT))
                begin
                    if (c == ".")
                        lex_mode = M_FRAC;
                    else if (lex_mode == M_INT)
                        take_digit(c);
                    lexeme_len = sat_inc(lexeme_len);
                    col_cnt = sat_inc(col_cnt);
                    return;
                end
                finish_num();
            end
            M_STRING:
            begin
                col_cnt = sat_inc(col_cnt);
                if (c == "'")
                begin
                    emit_token(K_STRING, lexeme_len, 0, 0);
                    lex_mode = M_IDLE;
                end
                else
                    lexeme_len = sat_inc(lexeme_len);
                return;
            end
            M_LT:
            begin
                if (c == ">" || c == "=")
                begin
                    col_cnt = sat_inc(col_cnt);
                    emit_token((c == ">") ? K_NE : K_LE, 2, 0, 0);
                    lex_mode = M_IDLE;
                    return;
                end
                emit_token(K_LT, 1, 0, 0);
            end
            M_GT, M_BANG:
            begin
                if (c == "=")
                begin
                    col_cnt = sat_inc(col_cnt);
                    emit_token((lex_mode == M_GT) ? K_GE : K_NE, 2, 0, 0);
                    lex_mode = M_IDLE;
                    return;
                end
                emit_token((lex_mode == M_GT) ? K_GT : K_ERROR, 1, 0, 0);
            end
            default: ;
        endcase
        lex_mode = M_IDLE;
        scan_fresh(c);
    endfunction

    function automatic void flush_pending();
        case (lex_mode)
            M_MINUS: emit_token(K_MINUS, 1, 0, 0);
            M_IDENT: finish_word();
            M_INT, M_FRAC: finish_num();
            M_STRING: emit_token(K_ERROR, lexeme_len, 0, 0);
            M_LT: emit_token(K_LT, 1, 0, 0);
            M_GT: emit_token(K_GT, 1, 0, 0);
            M_BANG: emit_token(K_ERROR, 1, 0, 0);
            default: ;
        endcase
        emit_token(K_END, 0, 0, 0);
        lexer_clear();
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        errors++;
        $display("mismatch at token %0d: %s got %0d expected %0d", tokens_seen, what, got,
                 want);
    endtask

    // predict the tokens of one accepted item
    task automatic predict_tokens(text_item_t it);
        run_tokens.delete();
        if (it.flush)
            flush_pending();
        else
            scan_char(it.ch);
        if (it.first_kind != NO_CHECK)
            if (run_tokens.size() == 0)
                report_mismatch("token count of directed item", 0, 1);
            else if (run_tokens[0].kind != it.first_kind)
                report_mismatch("directed kind", run_tokens[0].kind, it.first_kind);
        if (run_tokens.size() > 0)
            run_tokens[run_tokens.size() - 1].last = 1'b1;
        foreach (run_tokens[i])
            token_q.push_back(run_tokens[i]);
    endtask

    function automatic int pick_gap(bit burst);
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // sender
    int  send_gap = 0;
    bit  send_burst = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                predict_tokens('{s_tuser, s_tdata, text_q[0].first_kind});
                void'(text_q.pop_front());
                items_sent++;
                if (items_sent % 60 == 0)
                    send_burst = !send_burst;
            end
            if (!(s_tvalid && !s_tready))
            begin
                if (send_gap > 0 || text_q.size() == 0)
                begin
                    if (send_gap > 0)
                        send_gap--;
                    s_tvalid <= 1'b0;
                end
                else
                begin
                    s_tuser <= text_q[0].flush;
                    s_tdata <= text_q[0].ch;
                    s_tvalid <= 1'b1;
                    send_gap = pick_gap(send_burst);
                end
            end
        end
    end

    // receiver and checker
    int recv_gap = 0;
    always @(posedge clk)
    begin
        token_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                tokens_seen++;
                if (token_q.size() == 0)
                    report_mismatch("unexpected token kind", m_tuser[6:0], 0);
                else
                begin
                    want = token_q.pop_front();
                    if (m_tuser[6:0] != want.kind)
                        report_mismatch("kind", m_tuser[6:0], want.kind);
                    if (m_tuser[7] != want.frac_flag)
                        report_mismatch("float", m_tuser[7], want.frac_flag);
                    if (m_tdata[15:0] != want.line)
                        report_mismatch("line", m_tdata[15:0], want.line);
                    if (m_tdata[31:16] != want.column)
                        report_mismatch("column", m_tdata[31:16], want.column);
                    if (m_tdata[47:32] != want.length)
                        report_mismatch("length", m_tdata[47:32], want.length);
                    if (m_tdata[110:48] != want.ival)
                        report_mismatch("value", m_tdata[110:48], want.ival);
                    if (m_tlast != want.last)
                        report_mismatch("last", m_tlast, want.last);
                end
            end
            if (recv_gap > 0)
            begin
                recv_gap--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                recv_gap = pick_gap(send_burst);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else if (++idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic push_char(byte c, int chk = NO_CHECK);
        text_q.push_back('{1'b0, c, chk});
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i]);
    endtask

    task automatic push_keyword();
        int k;
        byte unsigned c;
        k = $urandom_range(0, 51);
        for (int b = 7; b >= 0; b--)
        begin
            c = kw_text[k][b*8 +: 8];
            if (c != 0)
                push_char($urandom_range(0, 1) ? c + 8'd32 : c);
        end
    endtask

    task automatic push_random_token();
        string ops[12] = '{"<>", "<=", ">=", "!=", "!", "<", ">", "-", "(", ")", ",;", "*+/="};
        string word_chars = "abcXYZ_019qwERTzM";
        int n;
        byte c;
        case ($urandom_range(0, 11))
            0, 1: push_keyword();
            2:
            begin
                n = $urandom_range(1, 3) == 1 ? $urandom_range(9, 13) : $urandom_range(1, 8);
                push_char(word_chars[$urandom_range(0, 6)]);
                for (int i = 1; i < n; i++)
                    push_char(word_chars[$urandom_range(0, word_chars.len() - 1)]);
            end
            3:
            begin
                n = $urandom_range(0, 3) == 0 ? $urandom_range(17, 22) : $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    push_char($urandom_range(48, 57));
                if ($urandom_range(0, 2) == 0)
                begin
                    push_char(".");
                    for (int i = $urandom_range(0, 3); i > 0; i--)
                        push_char($urandom_range(48, 57));
                    if ($urandom_range(0, 2) == 0)
                        push_char(".");
                end
            end
            4:
            begin
                push_char("'");
                for (int i = $urandom_range(0, 5); i > 0; i--)
                begin
                    c = $urandom_range(0, 255);
                    push_char(c == "'" ? 8'h0A : c);
                end
                if ($urandom_range(0, 9) != 0)
                    push_char("'");
            end
            5, 6: push_text(ops[$urandom_range(0, 11)]);
            7:
            begin
                push_text("--");
                for (int i = $urandom_range(0, 4); i > 0; i--)
                begin
                    c = $urandom_range(0, 255);
                    push_char(c == 8'h0A ? "x" : c);
                end
                push_char(8'h0A);
            end
            8: push_char($urandom_range(0, 255));
            9: if ($urandom_range(0, 2) == 0) text_q.push_back('{1'b1, 8'($urandom), NO_CHECK});
            default: ;
        endcase
        case ($urandom_range(0, 5))
            0: push_char(8'h0A);
            1: push_char(8'h09);
            2, 3: push_char(" ");
            default: ;
        endcase
    endtask

    initial
    begin
        text_item_t directed [] = '{
            '{0, "(", K_LPAREN}, '{0, 8'h00, K_ERROR}, '{0, 8'hFF, K_ERROR},
            '{0, "!", NO_CHECK}, '{0, "x", K_ERROR}, '{0, " ", K_IDENT},
            '{0, "<", NO_CHECK}, '{0, ">", K_NE}, '{0, ">", NO_CHECK}, '{0, "=", K_GE},
            '{0, "'", NO_CHECK}, '{0, 8'h0A, NO_CHECK}, '{0, "'", K_STRING},
            '{0, "-", NO_CHECK}, '{0, "-", NO_CHECK}, '{0, "z", NO_CHECK},
            '{0, 8'h0A, NO_CHECK}, '{0, "9", NO_CHECK}, '{0, ".", NO_CHECK},
            '{0, ".", K_NUMBER}, '{1, 8'h00, K_END}, '{0, "'", NO_CHECK},
            '{0, "a", NO_CHECK}, '{1, 8'h00, K_ERROR}};
        lexer_clear();
        foreach (directed[i])
            text_q.push_back(directed[i]);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        while (text_q.size() < 180)
            push_random_token();
        text_q.push_back('{1'b1, 8'h00, NO_CHECK});
        wait (text_q.size() == 0 && !s_tvalid);
        wait (token_q.size() == 0);
        repeat (20) @(posedge clk);
        $display("sent %0d text items (keywords, names, numbers, strings, operators,", items_sent);
        $display("comments, noise bytes, flushes) and checked %0d tokens", tokens_seen);
        if (errors == 0 && token_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
